@@ hw/rtl/qdv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdv_pkg
// Shared types, codes and tables for the quadrature decoder velocity unit.
// ----------------------------------------------------------------------------
package qdv_pkg;

  // field and register widths
  localparam int RATE_W    = 14;
  localparam int TIMEOUT_W = 16;
  localparam int LIMIT_W   = 14;
  localparam int SPEED_W   = 14;
  localparam int VEL_W     = 15;
  localparam int PHASE_W   = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  // quotient of a RATE_W-bit numerator never needs more than RATE_W bits
  localparam int QUO_W  = RATE_W;
  localparam int STEP_W = $clog2(QUO_W + 1);

  // register reset values
  localparam logic [RATE_W-1:0]    TICK_RATE_RST    = 14'd1000;
  localparam logic [TIMEOUT_W-1:0] STOP_TIMEOUT_RST = 16'd500;
  localparam logic [LIMIT_W-1:0]   SLOW_LIMIT_RST   = 14'd15;
  localparam logic [LIMIT_W-1:0]   FAST_LIMIT_RST   = 14'd50;

  // legal Gray-code moves, indexed by {stored phase, sampled phase}
  localparam logic [15:0] LEGAL_MOVE = 16'h6996;

  // moves out of phase 3 that close a speed measurement
  localparam logic [3:0] KEY_3_TO_1 = 4'd13;
  localparam logic [3:0] KEY_3_TO_2 = 4'd14;

  typedef enum logic [1:0] {
    REG_TICK_RATE    = 2'd0,
    REG_STOP_TIMEOUT = 2'd1,
    REG_SLOW_LIMIT   = 2'd2,
    REG_FAST_LIMIT   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    CLS_STOPPED = 2'd0,
    CLS_SLOW    = 2'd1,
    CLS_MEDIUM  = 2'd2,
    CLS_FAST    = 2'd3
  } speed_cls_t;

  // clockwise order 3,1,0,2; counterclockwise 3,2,0,1
  function automatic dir_t turn_dir(input logic [PHASE_W-1:0] prev,
                                    input logic [PHASE_W-1:0] cur);
    logic [3:0] pair;
    dir_t       d;
    pair = {prev, cur};
    unique case (pair)
      4'd11, 4'd13, 4'd4, 4'd2: d = DIR_CW;
      4'd7,  4'd14, 4'd8, 4'd1: d = DIR_CCW;
      default:                  d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qdv_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qdv_divider
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qdv_divider #(
  parameter int DIVISOR_W = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [qdv_pkg::QUO_W-1:0]     dividend,
  input  wire logic [DIVISOR_W-1:0]          divisor,
  output logic                               done,
  output logic [qdv_pkg::QUO_W-1:0]          quotient
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [qdv_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [DIVISOR_W-1:0]            rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]            den_r, den_nxt;
  logic [qdv_pkg::QUO_W-1:0]       quo_r, quo_nxt;
  logic [DIVISOR_W:0]              trial;
  logic [DIVISOR_W:0]              diff;
  logic                            fits;

  // shift next dividend bit into the partial remainder
  assign trial = {rem_r, quo_r[qdv_pkg::QUO_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = '0;
      den_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_nxt  = {quo_r[qdv_pkg::QUO_W-2:0], fits};
      step_nxt = step_r + qdv_pkg::STEP_W'(1);
      if (step_r == qdv_pkg::STEP_W'(qdv_pkg::QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ hw/rtl/quadrature_decoder_velocity_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadrature_decoder_velocity_unit
// Quadrature encoder decoder with tick-count velocity estimate.
// ----------------------------------------------------------------------------
// Each input item is one timer tick carrying the sampled A/B phase; each tick
// gives exactly one result item (phase, direction, signed velocity, speed
// class). A tick with a legal move out of phase 3 runs a bit-serial divide of
// tick_rate by the tick count, one quotient bit per cycle, before its result
// is built; any other tick goes from acceptance straight to the output state.
// No new tick is taken until the result is loaded into the output register.
// A finished result sits there, so the next tick is accepted while it waits.
// Registers (APB, byte address 4*i): 0 tick_rate, 1 stop_timeout,
// 2 slow_limit, 3 fast_limit. Write them only while the block is idle.
// ----------------------------------------------------------------------------
module quadrature_decoder_velocity_unit #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // input items
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [qdv_pkg::IN_DATA_W-1:0]     in_tdata,   // [1:0] encoder_bits
  // result items
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [qdv_pkg::OUT_DATA_W-1:0]         out_tdata,  // [1:0] phase,
                                                             // [3:2] direction,
                                                             // [18:4] velocity,
                                                             // [20:19] speed_class
  // configuration
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [qdv_pkg::PADDR_W-1:0]       cfg_paddr,
  input  wire logic [qdv_pkg::PDATA_W-1:0]       cfg_pwdata,
  output logic [qdv_pkg::PDATA_W-1:0]            cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int CmpW = (COUNT_WIDTH > qdv_pkg::TIMEOUT_W) ? COUNT_WIDTH
                                                           : qdv_pkg::TIMEOUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_OUT
  } state_t;

  // config registers
  logic [qdv_pkg::RATE_W-1:0]    tick_rate_r;
  logic [qdv_pkg::TIMEOUT_W-1:0] stop_timeout_r;
  logic [qdv_pkg::LIMIT_W-1:0]   slow_limit_r;
  logic [qdv_pkg::LIMIT_W-1:0]   fast_limit_r;
  logic                          cfg_wr;
  qdv_pkg::reg_idx_t             cfg_idx;

  // decoder state
  state_t                        state_r, state_nxt;
  logic [qdv_pkg::PHASE_W-1:0]   cur_r, cur_nxt;
  logic [qdv_pkg::PHASE_W-1:0]   prev_r, prev_nxt;
  logic [COUNT_WIDTH-1:0]        cnt_r, cnt_nxt;
  logic [qdv_pkg::SPEED_W-1:0]   speed_r, speed_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [qdv_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // per-tick working signals
  logic                          in_acc;
  logic [qdv_pkg::PHASE_W-1:0]   sample;
  logic [3:0]                    key;
  logic [COUNT_WIDTH-1:0]        cnt_inc;
  logic                          legal;
  logic                          div_start;
  logic                          div_done;
  logic [qdv_pkg::QUO_W-1:0]     div_quo;

  // result assembly
  qdv_pkg::dir_t                 dir;
  logic [qdv_pkg::SPEED_W-1:0]   mag;
  logic [qdv_pkg::VEL_W-1:0]     vel;
  qdv_pkg::speed_cls_t           cls;
  logic                          out_load;

  // ---------------------------------------------------------------- config
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = qdv_pkg::reg_idx_t'(cfg_paddr[qdv_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r    <= qdv_pkg::TICK_RATE_RST;
      stop_timeout_r <= qdv_pkg::STOP_TIMEOUT_RST;
      slow_limit_r   <= qdv_pkg::SLOW_LIMIT_RST;
      fast_limit_r   <= qdv_pkg::FAST_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        qdv_pkg::REG_TICK_RATE:    tick_rate_r    <= cfg_pwdata[qdv_pkg::RATE_W-1:0];
        qdv_pkg::REG_STOP_TIMEOUT: stop_timeout_r <= cfg_pwdata[qdv_pkg::TIMEOUT_W-1:0];
        qdv_pkg::REG_SLOW_LIMIT:   slow_limit_r   <= cfg_pwdata[qdv_pkg::LIMIT_W-1:0];
        qdv_pkg::REG_FAST_LIMIT:   fast_limit_r   <= cfg_pwdata[qdv_pkg::LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      qdv_pkg::REG_TICK_RATE:    cfg_prdata = qdv_pkg::PDATA_W'(tick_rate_r);
      qdv_pkg::REG_STOP_TIMEOUT: cfg_prdata = qdv_pkg::PDATA_W'(stop_timeout_r);
      qdv_pkg::REG_SLOW_LIMIT:   cfg_prdata = qdv_pkg::PDATA_W'(slow_limit_r);
      qdv_pkg::REG_FAST_LIMIT:   cfg_prdata = qdv_pkg::PDATA_W'(fast_limit_r);
    endcase
  end

  // ---------------------------------------------------------- tick decode
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign sample    = in_tdata[qdv_pkg::PHASE_W-1:0];
  assign key       = {cur_r, sample};
  assign legal     = qdv_pkg::LEGAL_MOVE[key];
  // counter sticks at all-ones
  assign cnt_inc   = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r
                                                    : cnt_r + COUNT_WIDTH'(1);
  // cnt_inc is at least one here, so the divide never sees zero
  assign div_start = in_acc && legal &&
                     (key == qdv_pkg::KEY_3_TO_1 || key == qdv_pkg::KEY_3_TO_2);

  qdv_divider #(
    .DIVISOR_W (COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tick_rate_r),
    .divisor  (cnt_inc),
    .done     (div_done),
    .quotient (div_quo)
  );

  // --------------------------------------------------------- result build
  assign dir = qdv_pkg::turn_dir(prev_r, cur_r);
  assign mag = (dir == qdv_pkg::DIR_NONE) ? '0 : speed_r;
  assign vel = (dir == qdv_pkg::DIR_CCW) ? -{1'b0, mag} : {1'b0, mag};

  // fast wins over slow if the limits are set out of order
  always_comb begin
    priority if (mag == '0)
      cls = qdv_pkg::CLS_STOPPED;
    else if (slow_limit_r < mag && mag <= fast_limit_r)
      cls = qdv_pkg::CLS_MEDIUM;
    else if (fast_limit_r < mag)
      cls = qdv_pkg::CLS_FAST;
    else
      cls = qdv_pkg::CLS_SLOW;
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    speed_nxt     = speed_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready)
      out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cnt_nxt   = cnt_inc;
          state_nxt = S_OUT;
          if (legal) begin
            prev_nxt = cur_r;
            cur_nxt  = sample;
            if (div_start)
              state_nxt = S_DIV;
          end else if (CmpW'(cnt_inc) >= CmpW'(stop_timeout_r)) begin
            speed_nxt = '0;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          speed_nxt = div_quo[qdv_pkg::SPEED_W-1:0];
          cnt_nxt   = '0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, cls, vel, dir, cur_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      prev_r      <= '0;
      cnt_r       <= '0;
      speed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      speed_r     <= speed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ----------------------------------------------------------- assertions
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_no_accept_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> !in_tready)
    else $error("tick accepted during division");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |=> cnt_r == '0)
    else $error("tick count not cleared after speed update");

  a_load_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_OUT)
    else $error("result loaded outside the output state");

endmodule
`default_nettype wire
